FILE: rtl/stq_pkg.sv
// Shared types and codes for the sorted timer queue.
// No dependencies; imported by sorted_timer_queue_unit.
`default_nettype none
package stq_pkg;

  localparam int ID_W      = 6;
  localparam int TIME_W    = 32;
  localparam int DEF_CAPACITY = 32;
  localparam int TICK_LIMIT   = 32;
  localparam int TICK_CNT_W   = 6;

  typedef logic [1:0]        req_t;
  typedef logic [1:0]        status_t;
  typedef logic [ID_W-1:0]   id_t;
  typedef logic [TIME_W-1:0] time_t;

  localparam req_t REQ_ADD    = 2'd0;
  localparam req_t REQ_ADJUST = 2'd1;
  localparam req_t REQ_DELETE = 2'd2;
  localparam req_t REQ_TICK   = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_DUPLICATE = 2'd3;

endpackage
`default_nettype wire

FILE: rtl/sorted_timer_queue_unit.sv
// Sorted timer queue top level: list memory plus the request sequencer.
// Depends on stq_pkg.
//
// Usage:
//  - Input channel (in_*): one request per transfer: add, adjust, delete or
//    tick. in_stall is high while a request is being worked on; a new
//    request is taken only when the sequencer is idle.
//  - Result channel (out_*): add, adjust and delete give one result. A tick
//    gives one result per expired timer (at most 32), or a single result
//    with fired low when nothing expired. out_last marks the final result.
//  - Steps: every list step is a memory read followed by a compare or a
//    write. Add and delete scan the list for the id and then shift the
//    entries behind that slot; an adjust that moves its timer also rescans
//    from just past its old slot to the tail. A tick pops expired timers
//    from the head, which moves through a ring pointer.
//  - A result sits in an output register; the sequencer keeps going while
//    it waits and only pauses when it has another result to place.
//  - Reset empties the list at once (occupancy and head pointer cleared);
//    memory contents are left as they are.
`default_nettype none
module sorted_timer_queue_unit #(
  parameter int CAPACITY = stq_pkg::DEF_CAPACITY
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire [1:0]           in_req_type,
  input  wire [5:0]           in_timer_id,
  input  wire [31:0]          in_expire_time,
  input  wire [31:0]          in_now_time,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [1:0]          out_status,
  output logic                out_fired,
  output logic [5:0]          out_fired_id,
  output logic                out_last
);
  import stq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int OW = $clog2(CAPACITY + 1);
  localparam logic [OW-1:0] CAP_V = OW'(CAPACITY);

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CMP = 4'd2;
  localparam logic [3:0] S_ADJ_CMP  = 4'd3;
  localparam logic [3:0] S_REM_RD   = 4'd4;
  localparam logic [3:0] S_REM_WR   = 4'd5;
  localparam logic [3:0] S_INS_RD   = 4'd6;
  localparam logic [3:0] S_INS_WR   = 4'd7;
  localparam logic [3:0] S_TK_RD    = 4'd8;
  localparam logic [3:0] S_TK_CMP   = 4'd9;
  localparam logic [3:0] S_TK_EMIT  = 4'd10;
  localparam logic [3:0] S_FIN      = 4'd11;

  // list memory, one synchronous read port and one write port
  id_t   mem_id  [CAPACITY];
  time_t mem_exp [CAPACITY];
  id_t   rd_id_r;
  time_t rd_exp_r;
  logic           rd_en, wr_en;
  logic [IW-1:0]  rd_addr, wr_addr;
  id_t            wr_id;
  time_t          wr_exp;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_addr]  <= wr_id;
      mem_exp[wr_addr] <= wr_exp;
    end
    if (rd_en) begin
      rd_id_r  <= mem_id[rd_addr];
      rd_exp_r <= mem_exp[rd_addr];
    end
  end

  logic [3:0]      state_r, state_nxt;
  req_t            req_r, req_nxt;
  id_t             id_r, id_nxt;
  time_t           exp_r, exp_nxt, now_r, now_nxt;
  logic [OW-1:0]   idx_r, idx_nxt, pos_r, pos_nxt, place_r, place_nxt;
  logic [OW-1:0]   occ_r, occ_nxt;
  logic [IW-1:0]   head_r, head_nxt;
  logic            found_r, found_nxt, place_set_r, place_set_nxt;
  logic            kind_r, kind_nxt;   // 0: id scan, 1: placement scan after adjust
  logic [TICK_CNT_W:0] cnt_r, cnt_nxt;
  logic            pend_r, pend_nxt;
  id_t             pend_id_r, pend_id_nxt, cur_id_r, cur_id_nxt;
  status_t         fin_status_r, fin_status_nxt;
  logic            fin_fired_r, fin_fired_nxt;
  id_t             fin_id_r, fin_id_nxt;
  logic            out_valid_r, out_valid_nxt;
  status_t         out_status_r, out_status_nxt;
  logic            out_fired_r, out_fired_nxt, out_last_r, out_last_nxt;
  id_t             out_id_r, out_id_nxt;

  logic            out_free;
  logic [OW:0]     idx_p1, pos_p1;

  // logical list index to memory address through the ring head
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] head,
                                         input logic [OW-1:0] i);
    logic [OW:0] s;
    s = (OW+1)'(head) + (OW+1)'(i);
    if (s >= (OW+1)'(CAPACITY)) s = s - (OW+1)'(CAPACITY);
    return s[IW-1:0];
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign idx_p1   = (OW+1)'(idx_r) + (OW+1)'(1);
  assign pos_p1   = (OW+1)'(pos_r) + (OW+1)'(1);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;  req_nxt = req_r;  id_nxt = id_r;
    exp_nxt = exp_r;  now_nxt = now_r;  idx_nxt = idx_r;  pos_nxt = pos_r;
    place_nxt = place_r;  occ_nxt = occ_r;  head_nxt = head_r;
    found_nxt = found_r;  place_set_nxt = place_set_r;  kind_nxt = kind_r;
    cnt_nxt = cnt_r;  pend_nxt = pend_r;  pend_id_nxt = pend_id_r;
    cur_id_nxt = cur_id_r;  fin_status_nxt = fin_status_r;
    fin_fired_nxt = fin_fired_r;  fin_id_nxt = fin_id_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_status_nxt = out_status_r;  out_fired_nxt = out_fired_r;
    out_last_nxt = out_last_r;  out_id_nxt = out_id_r;
    rd_en = 1'b0;  rd_addr = '0;  wr_en = 1'b0;  wr_addr = '0;
    wr_id = id_r;  wr_exp = exp_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_req_type;  id_nxt = in_timer_id;
          exp_nxt = in_expire_time;  now_nxt = in_now_time;
          idx_nxt = '0;  found_nxt = 1'b0;  place_set_nxt = 1'b0;
          kind_nxt = 1'b0;  cnt_nxt = '0;  pend_nxt = 1'b0;
          fin_status_nxt = ST_OK;  fin_fired_nxt = 1'b0;  fin_id_nxt = '0;
          state_nxt = (in_req_type == REQ_TICK) ? S_TK_RD : S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (idx_r == occ_r) begin
          if (kind_r) begin
            pos_nxt = place_set_r ? place_r : occ_r;
            idx_nxt = occ_r;
            state_nxt = S_INS_RD;
          end else begin
            priority case (req_r)
              REQ_ADD: begin
                if (found_r) begin
                  fin_status_nxt = ST_DUPLICATE;  state_nxt = S_FIN;
                end else if (occ_r == CAP_V) begin
                  fin_status_nxt = ST_FULL;  state_nxt = S_FIN;
                end else begin
                  pos_nxt = place_set_r ? place_r : occ_r;
                  idx_nxt = occ_r;
                  state_nxt = S_INS_RD;
                end
              end
              REQ_ADJUST: begin
                if (!found_r) begin
                  fin_status_nxt = ST_NOT_FOUND;  state_nxt = S_FIN;
                end else begin
                  wr_en = 1'b1;  wr_addr = phys(head_r, pos_r);
                  if (pos_p1 < (OW+1)'(occ_r)) begin
                    rd_en = 1'b1;  rd_addr = phys(head_r, pos_p1[OW-1:0]);
                    state_nxt = S_ADJ_CMP;
                  end else begin
                    state_nxt = S_FIN;
                  end
                end
              end
              default: begin
                if (!found_r) begin
                  fin_status_nxt = ST_NOT_FOUND;  state_nxt = S_FIN;
                end else begin
                  idx_nxt = pos_r;  state_nxt = S_REM_RD;
                end
              end
            endcase
          end
        end else begin
          rd_en = 1'b1;  rd_addr = phys(head_r, idx_r);
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (!kind_r && !found_r && rd_id_r == id_r) begin
          found_nxt = 1'b1;  pos_nxt = idx_r;
        end
        if (!place_set_r && exp_r < rd_exp_r) begin
          place_set_nxt = 1'b1;  place_nxt = idx_r;
        end
        idx_nxt = idx_p1[OW-1:0];
        state_nxt = S_SCAN_RD;
      end
      S_ADJ_CMP: begin
        if (!(exp_r < rd_exp_r)) begin
          idx_nxt = pos_r;  state_nxt = S_REM_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_REM_RD: begin
        if (idx_p1 >= (OW+1)'(occ_r)) begin
          occ_nxt = occ_r - OW'(1);
          if (req_r == REQ_DELETE) begin
            state_nxt = S_FIN;
          end else begin
            // moved timer goes after every later entry not above it
            kind_nxt = 1'b1;  place_set_nxt = 1'b0;
            idx_nxt = pos_p1[OW-1:0];
            state_nxt = S_SCAN_RD;
          end
        end else begin
          rd_en = 1'b1;  rd_addr = phys(head_r, idx_p1[OW-1:0]);
          state_nxt = S_REM_WR;
        end
      end
      S_REM_WR: begin
        wr_en = 1'b1;  wr_addr = phys(head_r, idx_r);
        wr_id = rd_id_r;  wr_exp = rd_exp_r;
        idx_nxt = idx_p1[OW-1:0];
        state_nxt = S_REM_RD;
      end
      S_INS_RD: begin
        if (idx_r == pos_r) begin
          wr_en = 1'b1;  wr_addr = phys(head_r, pos_r);
          occ_nxt = occ_r + OW'(1);
          state_nxt = S_FIN;
        end else begin
          rd_en = 1'b1;  rd_addr = phys(head_r, idx_r - OW'(1));
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        wr_en = 1'b1;  wr_addr = phys(head_r, idx_r);
        wr_id = rd_id_r;  wr_exp = rd_exp_r;
        idx_nxt = idx_r - OW'(1);
        state_nxt = S_INS_RD;
      end
      S_TK_RD: begin
        if (occ_r == '0 || cnt_r == (TICK_CNT_W+1)'(TICK_LIMIT)) begin
          fin_fired_nxt = pend_r;  fin_id_nxt = pend_r ? pend_id_r : '0;
          state_nxt = S_FIN;
        end else begin
          rd_en = 1'b1;  rd_addr = head_r;
          state_nxt = S_TK_CMP;
        end
      end
      S_TK_CMP: begin
        if (rd_exp_r <= now_r) begin
          cur_id_nxt = rd_id_r;
          head_nxt = (head_r == IW'(CAPACITY - 1)) ? '0 : head_r + IW'(1);
          occ_nxt = occ_r - OW'(1);
          cnt_nxt = cnt_r + (TICK_CNT_W+1)'(1);
          state_nxt = S_TK_EMIT;
        end else begin
          fin_fired_nxt = pend_r;  fin_id_nxt = pend_r ? pend_id_r : '0;
          state_nxt = S_FIN;
        end
      end
      S_TK_EMIT: begin
        // previous expired id goes out once another one is known to follow
        if (!pend_r) begin
          pend_nxt = 1'b1;  pend_id_nxt = cur_id_r;  state_nxt = S_TK_RD;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;  out_status_nxt = ST_OK;  out_fired_nxt = 1'b1;
          out_id_nxt = pend_id_r;  out_last_nxt = 1'b0;
          pend_id_nxt = cur_id_r;  state_nxt = S_TK_RD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;  out_status_nxt = fin_status_r;
          out_fired_nxt = fin_fired_r;  out_id_nxt = fin_id_r;
          out_last_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;  occ_r <= '0;  head_r <= '0;
      out_valid_r <= 1'b0;  pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;  occ_r <= occ_nxt;  head_r <= head_nxt;
      out_valid_r <= out_valid_nxt;  pend_r <= pend_nxt;
    end
    req_r <= req_nxt;  id_r <= id_nxt;  exp_r <= exp_nxt;  now_r <= now_nxt;
    idx_r <= idx_nxt;  pos_r <= pos_nxt;  place_r <= place_nxt;
    found_r <= found_nxt;  place_set_r <= place_set_nxt;  kind_r <= kind_nxt;
    cnt_r <= cnt_nxt;  pend_id_r <= pend_id_nxt;  cur_id_r <= cur_id_nxt;
    fin_status_r <= fin_status_nxt;  fin_fired_r <= fin_fired_nxt;
    fin_id_r <= fin_id_nxt;
    out_status_r <= out_status_nxt;  out_fired_r <= out_fired_nxt;
    out_last_r <= out_last_nxt;  out_id_r <= out_id_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_fired    = out_fired_r;
  assign out_fired_id = out_id_r;
  assign out_last     = out_last_r;

endmodule
`default_nettype wire
